// File: src/sfcm_pkg.sv
// Shared constants, codes and types of the SPI flash command master.
package sfcm_pkg;

  localparam int ADDRESS_BITS   = 24;
  localparam int MAX_READ_BYTES = 256;
  localparam int CMD_W          = 4;
  localparam int COUNT_W        = 9;
  localparam int BYTE_W         = 8;
  localparam int WORD_W         = BYTE_W + ADDRESS_BITS;
  localparam int CNT_W          = $clog2(WORD_W);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = QPTR_W + 1;

  localparam logic [BYTE_W-1:0] OPC_WREN    = 8'h06;
  localparam logic [BYTE_W-1:0] OPC_WRDIS   = 8'h04;
  localparam logic [BYTE_W-1:0] OPC_ERASE   = 8'hC7;
  localparam logic [BYTE_W-1:0] OPC_PDOWN   = 8'hB9;
  localparam logic [BYTE_W-1:0] OPC_RELEASE = 8'hAB;
  localparam logic [BYTE_W-1:0] OPC_RDSR    = 8'h05;
  localparam logic [BYTE_W-1:0] OPC_READ    = 8'h03;
  localparam logic [BYTE_W-1:0] OPC_WRITE   = 8'h02;

  localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_READ_BYTES);
  localparam logic [CNT_W-1:0]   NBITS_BYTE = CNT_W'(BYTE_W - 1);
  localparam logic [CNT_W-1:0]   NBITS_WORD = CNT_W'(WORD_W - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WREN    = 4'd0,
    CMD_WRDIS   = 4'd1,
    CMD_ERASE   = 4'd2,
    CMD_PDOWN   = 4'd3,
    CMD_RELEASE = 4'd4,
    CMD_RDSTAT  = 4'd5,
    CMD_READ    = 4'd6,
    CMD_WRITE   = 4'd7,
    CMD_WRBYTE  = 4'd8,
    CMD_MISOBIT = 4'd9
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RECV  = 2'd1,
    PH_WRITE = 2'd2
  } phase_e;

  // One unit of back-end work: either a serial shift run or a single period.
  typedef struct packed {
    logic              single;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  nbits_m1;
    logic              cs;
    logic              clk;
    logic [BYTE_W-1:0] val;
    logic              valid;
    logic              err;
  } job_t;

  typedef struct packed {
    logic              mosi;
    logic              cs;
    logic              clk;
    logic [BYTE_W-1:0] val;
    logic              valid;
    logic              last;
    logic              err;
  } result_t;

  function automatic logic [BYTE_W-1:0] simple_opcode(input cmd_e cmd);
    logic [BYTE_W-1:0] opc;
    case (cmd)
      CMD_WREN:    opc = OPC_WREN;
      CMD_WRDIS:   opc = OPC_WRDIS;
      CMD_ERASE:   opc = OPC_ERASE;
      CMD_PDOWN:   opc = OPC_PDOWN;
      CMD_RELEASE: opc = OPC_RELEASE;
      default:     opc = OPC_RDSR;
    endcase
    return opc;
  endfunction

endpackage

// File: src/sfcm_front.sv
// Front end: accepts host items, tracks the transaction phase and queues jobs.
module sfcm_front import sfcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    q_full_i,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [ADDRESS_BITS-1:0] address_i,
  input  logic [BYTE_W-1:0]       data_byte_i,
  input  logic                    final_byte_i,
  input  logic [COUNT_W-1:0]      byte_count_i,
  input  logic                    miso_i,
  output logic                    enq_o,
  output job_t                    job_o
);

  phase_e             phase_q, phase_d;
  logic [2:0]         bit_pos_q, bit_pos_d;
  logic [COUNT_W-1:0] bytes_q, bytes_d;
  logic [BYTE_W-1:0]  rx_shift_q, rx_shift_d;

  logic [BYTE_W-1:0]  rx_next;
  logic [2:0]         bit_pos_next;
  logic [COUNT_W-1:0] bytes_next;
  job_t               err_job;

  assign enq_o        = push_i && !q_full_i;
  assign rx_next      = {rx_shift_q[BYTE_W-2:0], miso_i};
  assign bit_pos_next = bit_pos_q + 3'd1;
  assign bytes_next   = bytes_q - COUNT_W'(1);

  always_comb begin
    err_job          = '0;
    err_job.single   = 1'b1;
    err_job.cs       = (phase_q != PH_IDLE);
    err_job.err      = 1'b1;
  end

  always_comb begin
    phase_d    = phase_q;
    bit_pos_d  = bit_pos_q;
    bytes_d    = bytes_q;
    rx_shift_d = rx_shift_q;
    job_o      = err_job;
    case (cmd_e'(cmd_i)) inside
      CMD_WREN, CMD_WRDIS, CMD_ERASE, CMD_PDOWN, CMD_RELEASE, CMD_RDSTAT: begin
        if (phase_q == PH_IDLE) begin
          job_o          = '0;
          job_o.word     = {simple_opcode(cmd_e'(cmd_i)), ADDRESS_BITS'(0)};
          job_o.nbits_m1 = NBITS_BYTE;
          if (cmd_e'(cmd_i) == CMD_RDSTAT) begin
            phase_d    = PH_RECV;
            bytes_d    = COUNT_W'(1);
            bit_pos_d  = '0;
            rx_shift_d = '0;
          end
        end
      end
      CMD_READ: begin
        if (phase_q == PH_IDLE && byte_count_i != '0 && byte_count_i <= MAX_COUNT) begin
          job_o          = '0;
          job_o.word     = {OPC_READ, address_i};
          job_o.nbits_m1 = NBITS_WORD;
          phase_d        = PH_RECV;
          bytes_d        = byte_count_i;
          bit_pos_d      = '0;
          rx_shift_d     = '0;
        end
      end
      CMD_WRITE: begin
        if (phase_q == PH_IDLE) begin
          job_o          = '0;
          job_o.word     = {OPC_WRITE, address_i};
          job_o.nbits_m1 = NBITS_WORD;
          phase_d        = PH_WRITE;
        end
      end
      CMD_WRBYTE: begin
        if (phase_q == PH_WRITE) begin
          job_o          = '0;
          job_o.word     = {data_byte_i, ADDRESS_BITS'(0)};
          job_o.nbits_m1 = NBITS_BYTE;
          if (final_byte_i) phase_d = PH_IDLE;
        end
      end
      CMD_MISOBIT: begin
        if (phase_q == PH_RECV) begin
          job_o        = '0;
          job_o.single = 1'b1;
          job_o.cs     = 1'b1;
          job_o.clk    = 1'b1;
          bit_pos_d    = bit_pos_next;
          rx_shift_d   = rx_next;
          if (bit_pos_next == 3'd0) begin
            job_o.val   = rx_next;
            job_o.valid = 1'b1;
            bytes_d     = bytes_next;
            rx_shift_d  = '0;
            if (bytes_next == '0) phase_d = PH_IDLE;
          end
        end
      end
      default: begin
        job_o = err_job;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      bit_pos_q  <= '0;
      bytes_q    <= '0;
      rx_shift_q <= '0;
    end else if (enq_o) begin
      phase_q    <= phase_d;
      bit_pos_q  <= bit_pos_d;
      bytes_q    <= bytes_d;
      rx_shift_q <= rx_shift_d;
    end
  end

  // A receive phase always has at least one byte still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RECV |-> bytes_q != '0)
    else $error("receive phase with no bytes remaining");

endmodule

// File: src/sfcm_queue.sv
// Job queue between the front end and the serial back end.
module sfcm_queue import sfcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_i,
  input  job_t job_i,
  input  logic deq_i,
  output job_t head_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_enq, do_deq;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_enq  = enq_i && !full_o;
  assign do_deq  = deq_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_enq) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_enq) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (do_deq) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + QCNT_W'(do_enq) - QCNT_W'(do_deq);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_enq && !do_deq) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("job queue count lost an entry");

endmodule

// File: src/sfcm_back.sv
// Back end: turns queued jobs into one result beat per serial clock period.
module sfcm_back import sfcm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    head_i,
  input  logic    head_valid_i,
  output logic    deq_o,
  input  logic    pop_i,
  output logic    out_valid_o,
  output result_t out_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q, res_d;
  logic             advance, produce, last_bit;
  logic [CNT_W-1:0] bit_idx;

  assign advance  = !out_valid_q || pop_i;
  assign produce  = head_valid_i && advance;
  assign last_bit = (cnt_q == head_i.nbits_m1);
  assign bit_idx  = CNT_W'(WORD_W - 1) - cnt_q;
  assign deq_o    = produce && (head_i.single || last_bit);

  always_comb begin
    res_d = '0;
    if (head_i.single) begin
      res_d.mosi  = 1'b1;
      res_d.cs    = head_i.cs;
      res_d.clk   = head_i.clk;
      res_d.val   = head_i.val;
      res_d.valid = head_i.valid;
      res_d.last  = 1'b1;
      res_d.err   = head_i.err;
    end else begin
      res_d.mosi  = head_i.word[bit_idx];
      res_d.cs    = 1'b1;
      res_d.clk   = 1'b1;
      res_d.last  = last_bit;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (produce && !head_i.single) cnt_d = last_bit ? '0 : cnt_q + CNT_W'(1);
    out_valid_d = out_valid_q;
    if (produce) out_valid_d = 1'b1;
    else if (pop_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) out_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.err |-> out_q.last && !out_q.clk)
    else $error("error beat not a lone non-clock beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.valid |-> out_q.last && out_q.clk && out_q.cs)
    else $error("received byte on a malformed beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> head_valid_i && !head_i.single)
    else $error("shift counter running without a shift job");

endmodule

// File: src/spi_flash_command_master_top.sv
// Top level of the SPI flash command master: front end, job queue, back end.
// The first result beat of an item is queued at accept, then registered in the back end.
// Throughput: one result beat per cycle out of the back end unless the output is held;
//   a MISO bit or error is one beat, other items one beat per opcode, address or data bit.
// The serial back end sets the rate; the front end runs ahead through a 4-deep job queue.
// Reset (rst_ni low, asynchronous): phase idle, counters cleared, queue and output empty.
module spi_flash_command_master_top import sfcm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input side
  input  logic                    push,
  output logic                    full,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [ADDRESS_BITS-1:0] address_i,
  input  logic [BYTE_W-1:0]       data_byte_i,
  input  logic                    final_byte_i,
  input  logic [COUNT_W-1:0]      byte_count_i,
  input  logic                    miso_i,
  // result side
  output logic                    empty,
  input  logic                    pop,
  output logic                    mosi_o,
  output logic                    chip_select_active_o,
  output logic                    clock_pulse_o,
  output logic [BYTE_W-1:0]       read_value_o,
  output logic                    read_valid_o,
  output logic                    last_o,
  output logic                    error_o
);

  // Front end to queue.
  logic    enq;
  job_t    job;
  // Queue to back end.
  job_t    head;
  logic    q_full, q_empty, deq;
  // Back end output register.
  logic    out_valid;
  result_t res;

  // Front end: classify the item, update phase and receive state at accept.
  sfcm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .q_full_i     (q_full),
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .byte_count_i (byte_count_i),
    .miso_i       (miso_i),
    .enq_o        (enq),
    .job_o        (job)
  );

  // Decouple the two sides: hold jobs while the serial side is busy.
  sfcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .job_i   (job),
    .deq_i   (deq),
    .head_o  (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end: advance one serial clock period per beat, stall on a full output.
  sfcm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_empty),
    .deq_o        (deq),
    .pop_i        (pop && out_valid),
    .out_valid_o  (out_valid),
    .out_o        (res)
  );

  assign full                 = q_full;
  assign empty                = !out_valid;
  assign mosi_o               = res.mosi;
  assign chip_select_active_o = res.cs;
  assign clock_pulse_o        = res.clk;
  assign read_value_o         = res.val;
  assign read_valid_o         = res.valid;
  assign last_o               = res.last;
  assign error_o              = res.err;

endmodule
